[hdl/assert_macros.svh]
// assertion macros shared by the histogram rtl
// expects clk and rst_n in the including module
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, checked out of reset
`define ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked out of reset
`define ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[hdl/hthws_pkg.sv]
// shared types and constants of the hit time histogram block
// no dependencies
package hthws_pkg;

  localparam int unsigned NUM_BINS_DEF   = 1024;
  localparam int unsigned COUNT_BITS_DEF = 16;

  localparam int unsigned OP_W        = 2;
  localparam int unsigned TIME_W      = 32;
  localparam int unsigned BIN_FIELD_W = 10;
  localparam int unsigned TOTAL_W     = 26;
  localparam int unsigned WIDTH_W     = 16;
  localparam int unsigned BCOUNT_W    = 11;
  localparam int unsigned CFG_ADDR_W  = 2;
  localparam int unsigned CFG_DATA_W  = 32;
  localparam int unsigned DIFF_W      = TIME_W + 2;
  localparam int unsigned DVD_W       = DIFF_W - 1;

  localparam logic [TOTAL_W-1:0]       TOTAL_MAX     = '1;
  localparam logic signed [TIME_W-1:0] T_LEFT_RST    = '0;
  localparam logic [WIDTH_W-1:0]       BIN_WIDTH_RST = WIDTH_W'(16);
  localparam logic [BCOUNT_W-1:0]      BIN_COUNT_RST = BCOUNT_W'(1024);
  localparam logic signed [TIME_W-1:0] FLIGHT_TOP    = {1'b0, {(TIME_W-1){1'b1}}};
  localparam logic signed [TIME_W-1:0] FLIGHT_BOTTOM = {1'b1, {(TIME_W-1){1'b0}}};

  typedef enum logic [OP_W-1:0] {
    OP_INSERT = 2'd0,
    OP_QUERY  = 2'd1,
    OP_CLEAR  = 2'd2
  } op_t;

  typedef enum logic [CFG_ADDR_W-1:0] {
    CFG_T_LEFT    = 2'd0,
    CFG_BIN_WIDTH = 2'd1,
    CFG_BIN_COUNT = 2'd2
  } cfg_idx_t;

  typedef enum logic [2:0] {
    ST_SWEEP,
    ST_IDLE,
    ST_DIVIDE,
    ST_BUMP,
    ST_SUM
  } state_t;

  typedef struct packed {
    logic               start;
    logic [DVD_W-1:0]   dividend;
    logic [WIDTH_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [DVD_W-1:0] quotient;
  } div_rsp_t;

endpackage

[hdl/hthws_divider.sv]
// radix-2 restoring divider, one quotient bit per cycle
// depends on hthws_pkg and assert_macros.svh
`include "assert_macros.svh"

module hthws_divider (
  input  logic                clk,
  input  logic                rst_n,
  input  hthws_pkg::div_req_t req,
  output hthws_pkg::div_rsp_t rsp
);
  import hthws_pkg::*;

  localparam int unsigned CNT_W = $clog2(DVD_W);

  logic               busy_r, busy_nxt;
  logic               done_r, done_nxt;
  logic [CNT_W-1:0]   cnt_r, cnt_nxt;
  logic [WIDTH_W-1:0] rem_r, rem_nxt;
  logic [DVD_W-1:0]   quo_r, quo_nxt;
  logic [WIDTH_W-1:0] divisor_r, divisor_nxt;

  logic [WIDTH_W:0]   rem_sh;
  logic [WIDTH_W:0]   rem_sub;
  logic               fits;

  assign rem_sh  = {rem_r, quo_r[DVD_W-1]};
  assign rem_sub = rem_sh - {1'b0, divisor_r};
  assign fits    = rem_sh >= {1'b0, divisor_r};

  always_comb begin
    busy_nxt    = busy_r;
    cnt_nxt     = cnt_r;
    rem_nxt     = rem_r;
    quo_nxt     = quo_r;
    divisor_nxt = divisor_r;
    done_nxt    = busy_r && (cnt_r == '0);
    if (!busy_r && req.start) begin
      busy_nxt    = 1'b1;
      cnt_nxt     = CNT_W'(DVD_W - 1);
      rem_nxt     = '0;
      quo_nxt     = req.dividend;
      divisor_nxt = req.divisor;
    end else if (busy_r) begin
      rem_nxt = fits ? rem_sub[WIDTH_W-1:0] : rem_sh[WIDTH_W-1:0];
      quo_nxt = {quo_r[DVD_W-2:0], fits};
      if (cnt_r == '0) begin
        busy_nxt = 1'b0;
      end else begin
        cnt_nxt = cnt_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cnt_r     <= cnt_nxt;
    rem_r     <= rem_nxt;
    quo_r     <= quo_nxt;
    divisor_r <= divisor_nxt;
  end

  assign rsp.done     = done_r;
  assign rsp.quotient = quo_r;

  `ASSERT_NXT(a_div_done_pulse, done_r, !done_r, "divider done lasted more than one cycle")
  `ASSERT_NXT(a_div_load, req.start && !busy_r, busy_r && (cnt_r == CNT_W'(DVD_W - 1)), "divider did not load")
  `ASSERT_IMP(a_div_rem_bound, busy_r && (divisor_r != '0), rem_r < divisor_r, "partial remainder out of range")

endmodule

[hdl/hit_time_histogram_window_sum.sv]
// top level: time histogram with window sum, bin store memory and control
// depends on hthws_pkg, hthws_divider and assert_macros.svh
//
//   channel  | ports                                  | handshake
//   ---------+----------------------------------------+------------------------------
//   input    | in_operation .. in_last_bin            | start high while busy low
//   result   | out_accepted .. out_flight_max         | out_valid strobe, one cycle
//   config   | cfg_addr, cfg_data                     | cfg_we, taken at once
//
// one transaction at a time; path from acceptance to the result strobe:
//   insert rejected up front (negative offset or zero width): strobe straight from idle
//   insert through the divider: the 33 steps of the serial divider, then the bin update
//   window sum: straight from idle on a cache hit or an empty window, else a walk
//     over the window, one bin per cycle through the memory read port
//   clear: result strobe, then a zeroing pass over all bins while busy
// after reset the same zeroing pass runs before start is taken;
// config writes are taken any time. results cannot be stalled by the receiver.
`include "assert_macros.svh"

module hit_time_histogram_window_sum #(
  parameter int unsigned NUM_BINS   = hthws_pkg::NUM_BINS_DEF,
  parameter int unsigned COUNT_BITS = hthws_pkg::COUNT_BITS_DEF
) (
  input  logic                                    clk,
  input  logic                                    rst_n,
  // input transaction
  input  logic                                    start,
  output logic                                    busy,
  input  logic [hthws_pkg::OP_W-1:0]              in_operation,
  input  logic signed [hthws_pkg::TIME_W-1:0]     in_raw_time,
  input  logic signed [hthws_pkg::TIME_W-1:0]     in_flight_time,
  input  logic [hthws_pkg::BIN_FIELD_W-1:0]       in_first_bin,
  input  logic [hthws_pkg::BIN_FIELD_W-1:0]       in_last_bin,
  // result transaction
  output logic                                    out_valid,
  output logic                                    out_accepted,
  output logic [hthws_pkg::BIN_FIELD_W-1:0]       out_hit_bin,
  output logic [hthws_pkg::TOTAL_W-1:0]           out_window_total,
  output logic signed [hthws_pkg::TIME_W-1:0]     out_flight_min,
  output logic signed [hthws_pkg::TIME_W-1:0]     out_flight_max,
  // configuration writes
  input  logic                                    cfg_we,
  input  logic [hthws_pkg::CFG_ADDR_W-1:0]        cfg_addr,
  input  logic [hthws_pkg::CFG_DATA_W-1:0]        cfg_data
);
  import hthws_pkg::*;

  localparam int unsigned BIN_W  = $clog2(NUM_BINS);
  localparam int unsigned USED_W = ($clog2(NUM_BINS + 1) > BCOUNT_W) ?
                                   $clog2(NUM_BINS + 1) : BCOUNT_W;
  localparam int unsigned SUM_W  = ((COUNT_BITS > TOTAL_W) ? COUNT_BITS : TOTAL_W) + 1;
  localparam logic [BIN_W-1:0]      SWEEP_LAST = BIN_W'(NUM_BINS - 1);
  localparam logic [COUNT_BITS-1:0] CNT_MAX    = '1;

  // control state
  state_t                    state_r, state_nxt;
  logic [BIN_W-1:0]          sweep_idx_r, sweep_idx_nxt;
  logic                      issue_r, issue_nxt;
  logic                      pend_r, pend_nxt;
  logic                      out_valid_r, out_valid_nxt;

  // configuration registers
  logic signed [TIME_W-1:0]  t_left_r, t_left_nxt;
  logic [WIDTH_W-1:0]        bin_width_r, bin_width_nxt;
  logic [BCOUNT_W-1:0]       bin_count_r, bin_count_nxt;

  // running extremes and window cache
  logic signed [TIME_W-1:0]  least_r, least_nxt;
  logic signed [TIME_W-1:0]  greatest_r, greatest_nxt;
  logic                      cache_valid_r, cache_valid_nxt;
  logic [BIN_FIELD_W-1:0]    cached_first_r, cached_first_nxt;
  logic [BIN_FIELD_W-1:0]    cached_last_r, cached_last_nxt;
  logic [TOTAL_W-1:0]        cached_total_r, cached_total_nxt;

  // per-transaction payload
  logic signed [TIME_W-1:0]  tof_r, tof_nxt;
  logic [BIN_W-1:0]          bin_r, bin_nxt;
  logic [BIN_W-1:0]          rd_idx_r, rd_idx_nxt;
  logic [BIN_W-1:0]          end_r, end_nxt;
  logic [TOTAL_W-1:0]        acc_r, acc_nxt;
  logic                      out_accepted_r, out_accepted_nxt;
  logic [BIN_FIELD_W-1:0]    out_hit_bin_r, out_hit_bin_nxt;
  logic [TOTAL_W-1:0]        out_total_r, out_total_nxt;

  // bin count memory, one write and one registered read port
  logic [COUNT_BITS-1:0]     bin_mem [NUM_BINS];
  logic                      mem_we;
  logic [BIN_W-1:0]          mem_waddr;
  logic [COUNT_BITS-1:0]     mem_wdata;
  logic [BIN_W-1:0]          mem_raddr;
  logic [COUNT_BITS-1:0]     mem_rdata_r;

  // divider link
  div_req_t                  div_req;
  div_rsp_t                  div_rsp;

  // datapath helpers
  logic [USED_W-1:0]         used;
  logic signed [DIFF_W-1:0]  diff;
  logic [USED_W-1:0]         first_ext;
  logic [USED_W-1:0]         last_ext;
  logic [USED_W-1:0]         last_clip;
  logic                      win_empty;
  logic                      cache_hit;
  logic [SUM_W-1:0]          sum_wide;
  logic [TOTAL_W-1:0]        sum_sat;

  hthws_divider u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  // bins in use: min(bin_count, NUM_BINS)
  assign used = (USED_W'(bin_count_r) < USED_W'(NUM_BINS)) ?
                USED_W'(bin_count_r) : USED_W'(NUM_BINS);

  // corrected time relative to the left edge, cannot overflow 34 bits
  assign diff = {{(DIFF_W-TIME_W){in_raw_time[TIME_W-1]}}, in_raw_time}
              - {{(DIFF_W-TIME_W){in_flight_time[TIME_W-1]}}, in_flight_time}
              - {{(DIFF_W-TIME_W){t_left_r[TIME_W-1]}}, t_left_r};

  assign first_ext = USED_W'(in_first_bin);
  assign last_ext  = USED_W'(in_last_bin);
  assign win_empty = (in_first_bin > in_last_bin) || (first_ext >= used);
  assign last_clip = (last_ext < used) ? last_ext : (used - 1'b1);
  assign cache_hit = cache_valid_r && (in_first_bin == cached_first_r)
                     && (in_last_bin == cached_last_r);

  // saturating window accumulation
  assign sum_wide = SUM_W'(acc_r) + SUM_W'(mem_rdata_r);
  assign sum_sat  = (sum_wide > SUM_W'(TOTAL_MAX)) ? TOTAL_MAX : sum_wide[TOTAL_W-1:0];

  // next state and outputs
  always_comb begin
    state_nxt        = state_r;
    sweep_idx_nxt    = sweep_idx_r;
    issue_nxt        = issue_r;
    pend_nxt         = pend_r;
    out_valid_nxt    = 1'b0;
    t_left_nxt       = t_left_r;
    bin_width_nxt    = bin_width_r;
    bin_count_nxt    = bin_count_r;
    least_nxt        = least_r;
    greatest_nxt     = greatest_r;
    cache_valid_nxt  = cache_valid_r;
    cached_first_nxt = cached_first_r;
    cached_last_nxt  = cached_last_r;
    cached_total_nxt = cached_total_r;
    tof_nxt          = tof_r;
    bin_nxt          = bin_r;
    rd_idx_nxt       = rd_idx_r;
    end_nxt          = end_r;
    acc_nxt          = acc_r;
    out_accepted_nxt = 1'b0;
    out_hit_bin_nxt  = '0;
    out_total_nxt    = '0;
    mem_we           = 1'b0;
    mem_waddr        = bin_r;
    mem_wdata        = '0;
    mem_raddr        = rd_idx_r;
    div_req.start    = 1'b0;
    div_req.dividend = diff[DVD_W-1:0];
    div_req.divisor  = bin_width_r;

    // register writes drop the cached window
    if (cfg_we) begin
      case (cfg_idx_t'(cfg_addr))
        CFG_T_LEFT: begin
          t_left_nxt      = cfg_data;
          cache_valid_nxt = 1'b0;
        end
        CFG_BIN_WIDTH: begin
          bin_width_nxt   = cfg_data[WIDTH_W-1:0];
          cache_valid_nxt = 1'b0;
        end
        CFG_BIN_COUNT: begin
          bin_count_nxt   = cfg_data[BCOUNT_W-1:0];
          cache_valid_nxt = 1'b0;
        end
        default: ;
      endcase
    end

    case (state_r)
      ST_SWEEP: begin
        // zero one bin per cycle
        mem_we        = 1'b1;
        mem_waddr     = sweep_idx_r;
        sweep_idx_nxt = sweep_idx_r + 1'b1;
        if (sweep_idx_r == SWEEP_LAST) begin
          sweep_idx_nxt = '0;
          state_nxt     = ST_IDLE;
        end
      end

      ST_IDLE: begin
        if (start) begin
          case (op_t'(in_operation))
            OP_INSERT: begin
              cache_valid_nxt = 1'b0;
              tof_nxt         = in_flight_time;
              // negative offset means a negative bin, reject at once
              if ((bin_width_r != '0) && !diff[DIFF_W-1]) begin
                div_req.start = 1'b1;
                state_nxt     = ST_DIVIDE;
              end else begin
                out_valid_nxt = 1'b1;
              end
            end
            OP_QUERY: begin
              cached_first_nxt = in_first_bin;
              cached_last_nxt  = in_last_bin;
              cache_valid_nxt  = 1'b1;
              if (cache_hit) begin
                out_valid_nxt = 1'b1;
                out_total_nxt = cached_total_r;
              end else if (win_empty) begin
                out_valid_nxt    = 1'b1;
                cached_total_nxt = '0;
              end else begin
                rd_idx_nxt = BIN_W'(in_first_bin);
                end_nxt    = BIN_W'(last_clip);
                issue_nxt  = 1'b1;
                pend_nxt   = 1'b0;
                acc_nxt    = '0;
                state_nxt  = ST_SUM;
              end
            end
            OP_CLEAR: begin
              least_nxt       = FLIGHT_TOP;
              greatest_nxt    = FLIGHT_BOTTOM;
              cache_valid_nxt = 1'b0;
              out_valid_nxt   = 1'b1;
              sweep_idx_nxt   = '0;
              state_nxt       = ST_SWEEP;
            end
            default: begin
              // unused code, report current extremes only
              out_valid_nxt = 1'b1;
            end
          endcase
        end
      end

      ST_DIVIDE: begin
        if (div_rsp.done) begin
          if (div_rsp.quotient < DVD_W'(used)) begin
            mem_raddr = div_rsp.quotient[BIN_W-1:0];
            bin_nxt   = div_rsp.quotient[BIN_W-1:0];
            state_nxt = ST_BUMP;
          end else begin
            out_valid_nxt = 1'b1;
            state_nxt     = ST_IDLE;
          end
        end
      end

      ST_BUMP: begin
        // read-modify-write of the hit bin, saturating count
        mem_we    = 1'b1;
        mem_waddr = bin_r;
        mem_wdata = (mem_rdata_r == CNT_MAX) ? mem_rdata_r : (mem_rdata_r + 1'b1);
        if (tof_r < least_r) begin
          least_nxt = tof_r;
        end
        if (tof_r > greatest_r) begin
          greatest_nxt = tof_r;
        end
        out_valid_nxt    = 1'b1;
        out_accepted_nxt = 1'b1;
        out_hit_bin_nxt  = BIN_FIELD_W'(bin_r);
        state_nxt        = ST_IDLE;
      end

      ST_SUM: begin
        // one read issued per cycle, its data summed from the registered read port
        mem_raddr = rd_idx_r;
        if (issue_r) begin
          pend_nxt = 1'b1;
          if (rd_idx_r == end_r) begin
            issue_nxt = 1'b0;
          end else begin
            rd_idx_nxt = rd_idx_r + 1'b1;
          end
        end else begin
          pend_nxt = 1'b0;
        end
        if (pend_r) begin
          acc_nxt = sum_sat;
        end
        if (pend_r && !issue_r) begin
          out_valid_nxt    = 1'b1;
          out_total_nxt    = sum_sat;
          cached_total_nxt = sum_sat;
          state_nxt        = ST_IDLE;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_SWEEP;
    end else begin
      state_r <= state_nxt;
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sweep_idx_r    <= '0;
      issue_r        <= 1'b0;
      pend_r         <= 1'b0;
      out_valid_r    <= 1'b0;
      t_left_r       <= T_LEFT_RST;
      bin_width_r    <= BIN_WIDTH_RST;
      bin_count_r    <= BIN_COUNT_RST;
      least_r        <= FLIGHT_TOP;
      greatest_r     <= FLIGHT_BOTTOM;
      cache_valid_r  <= 1'b0;
      cached_first_r <= '0;
      cached_last_r  <= '0;
      cached_total_r <= '0;
    end else begin
      sweep_idx_r    <= sweep_idx_nxt;
      issue_r        <= issue_nxt;
      pend_r         <= pend_nxt;
      out_valid_r    <= out_valid_nxt;
      t_left_r       <= t_left_nxt;
      bin_width_r    <= bin_width_nxt;
      bin_count_r    <= bin_count_nxt;
      least_r        <= least_nxt;
      greatest_r     <= greatest_nxt;
      cache_valid_r  <= cache_valid_nxt;
      cached_first_r <= cached_first_nxt;
      cached_last_r  <= cached_last_nxt;
      cached_total_r <= cached_total_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    tof_r          <= tof_nxt;
    bin_r          <= bin_nxt;
    rd_idx_r       <= rd_idx_nxt;
    end_r          <= end_nxt;
    acc_r          <= acc_nxt;
    out_accepted_r <= out_accepted_nxt;
    out_hit_bin_r  <= out_hit_bin_nxt;
    out_total_r    <= out_total_nxt;
  end

  // bin count memory
  always_ff @(posedge clk) begin
    if (mem_we) begin
      bin_mem[mem_waddr] <= mem_wdata;
    end
    mem_rdata_r <= bin_mem[mem_raddr];
  end

  assign busy             = (state_r != ST_IDLE) || !rst_n;
  assign out_valid        = out_valid_r;
  assign out_accepted     = out_accepted_r;
  assign out_hit_bin      = out_hit_bin_r;
  assign out_window_total = out_total_r;
  // extremes registers already hold the post-transaction values
  assign out_flight_min   = least_r;
  assign out_flight_max   = greatest_r;

  `ASSERT_NXT(a_sweep_ends, (state_r == ST_SWEEP) && (sweep_idx_r == SWEEP_LAST), state_r == ST_IDLE, "zeroing pass did not end in idle")
  `ASSERT_IMP(a_bump_after_div, state_r == ST_BUMP, $past(state_r) == ST_DIVIDE, "bin update without a division")
  `ASSERT_IMP(a_no_write_in_sum, state_r == ST_SUM, !mem_we, "memory written during a window walk")
  `ASSERT_IMP(a_accept_from_bump, out_valid_r && out_accepted_r, $past(state_r) == ST_BUMP, "accepted hit reported without a bin update")

endmodule

[tb/tb_hit_time_histogram_window_sum.sv]
// self-checking testbench for the hit time histogram with window sum
// depends on hthws_pkg and hit_time_histogram_window_sum; drives command
// transactions, register writes, and checks every result against a predictor or a hand-written expectation
module tb_hit_time_histogram_window_sum;
  import hthws_pkg::*;

  // ---------------------------------------------------------------------------
  // constants of the run
  // ---------------------------------------------------------------------------
  localparam int unsigned NBINS          = NUM_BINS_DEF;
  localparam int unsigned TALLY_MAX      = (1 << COUNT_BITS_DEF) - 1;
  localparam longint      TOTAL_CEIL     = (longint'(1) << TOTAL_W) - 1;
  localparam longint      TIME_TOP       = longint'(FLIGHT_TOP);
  localparam longint      TIME_BOTTOM    = longint'(FLIGHT_BOTTOM);
  localparam int          RANDOM_ITEMS   = 1400;
  localparam int          MAX_GAP        = 11;
  localparam int          REPORT_LIMIT   = 10;
  // slowest legal item: full-range window walk plus a pending zeroing pass
  // plus the longest sender gap; about 1500 items, then several times over
  localparam longint      CYCLE_LIMIT    = 10_000_000;
  localparam int          TAIL_CYCLES    = NBINS + 64;

  // operation code the block does not define, and a register index it ignores
  localparam logic [OP_W-1:0]       OP_UNUSED    = 2'd3;
  localparam logic [CFG_ADDR_W-1:0] CFG_NO_REG   = 2'd3;

  // ---------------------------------------------------------------------------
  // transaction types
  // ---------------------------------------------------------------------------
  typedef struct packed {
    logic [OP_W-1:0]          op;
    logic signed [TIME_W-1:0] raw;
    logic signed [TIME_W-1:0] tof;
    logic [BIN_FIELD_W-1:0]   first;
    logic [BIN_FIELD_W-1:0]   last;
  } hist_cmd_t;

  typedef struct packed {
    logic                     accepted;
    logic [BIN_FIELD_W-1:0]   hit_bin;
    logic [TOTAL_W-1:0]       window_total;
    logic signed [TIME_W-1:0] flight_min;
    logic signed [TIME_W-1:0] flight_max;
  } hist_result_t;

  // one row of the directed table: either a register write or a transaction,
  // the latter with an optional hand-written expectation
  typedef struct packed {
    logic                  is_write;
    logic [CFG_ADDR_W-1:0] reg_idx;
    logic [CFG_DATA_W-1:0] wdata;
    hist_cmd_t             cmd;
    logic                  typed;
    hist_result_t          want;
  } table_row_t;

  // ---------------------------------------------------------------------------
  // clock, reset and block ports
  // ---------------------------------------------------------------------------
  logic                      clk            = 1'b0;
  logic                      rst_n          = 1'b0;
  logic                      start          = 1'b0;
  logic [OP_W-1:0]           in_operation   = '0;
  logic signed [TIME_W-1:0]  in_raw_time    = '0;
  logic signed [TIME_W-1:0]  in_flight_time = '0;
  logic [BIN_FIELD_W-1:0]    in_first_bin   = '0;
  logic [BIN_FIELD_W-1:0]    in_last_bin    = '0;
  logic                      cfg_we         = 1'b0;
  logic [CFG_ADDR_W-1:0]     cfg_addr       = '0;
  logic [CFG_DATA_W-1:0]     cfg_data       = '0;

  logic                      busy;
  logic                      out_valid;
  logic                      out_accepted;
  logic [BIN_FIELD_W-1:0]    out_hit_bin;
  logic [TOTAL_W-1:0]        out_window_total;
  logic signed [TIME_W-1:0]  out_flight_min;
  logic signed [TIME_W-1:0]  out_flight_max;

  always #2 clk = ~clk;

  hit_time_histogram_window_sum u_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .start            (start),
    .busy             (busy),
    .in_operation     (in_operation),
    .in_raw_time      (in_raw_time),
    .in_flight_time   (in_flight_time),
    .in_first_bin     (in_first_bin),
    .in_last_bin      (in_last_bin),
    .out_valid        (out_valid),
    .out_accepted     (out_accepted),
    .out_hit_bin      (out_hit_bin),
    .out_window_total (out_window_total),
    .out_flight_min   (out_flight_min),
    .out_flight_max   (out_flight_max),
    .cfg_we           (cfg_we),
    .cfg_addr         (cfg_addr),
    .cfg_data         (cfg_data)
  );

  // ---------------------------------------------------------------------------
  // histogram predictor: own copy of the registers and of the bin store
  // ---------------------------------------------------------------------------
  logic signed [TIME_W-1:0]  span_left  = T_LEFT_RST;
  logic [WIDTH_W-1:0]        span_width = BIN_WIDTH_RST;
  logic [BCOUNT_W-1:0]       span_bins  = BIN_COUNT_RST;
  logic [COUNT_BITS_DEF-1:0] bin_tally [NBINS];
  logic signed [TIME_W-1:0]  least_tof;
  logic signed [TIME_W-1:0]  greatest_tof;

  // expectations in order of acceptance, one per transaction
  hist_result_t pending_results [$];

  // bookkeeping
  longint cycle_count    = 0;
  int     mismatch_count = 0;
  int     result_count   = 0;
  int     n_inserts      = 0;
  int     n_binned       = 0;
  int     n_queries      = 0;
  int     n_clears       = 0;
  int     n_unused_ops   = 0;
  int     n_writes       = 0;
  int     n_settings     = 0;

  // random stimulus memory: last window for repeats and slides, a hot bin
  // per setting so some bins build up large counts, and no-gap stretches
  logic [BIN_FIELD_W-1:0] prev_first = '0;
  logic [BIN_FIELD_W-1:0] prev_last  = '0;
  int                     hot_bin    = 0;
  int                     calm_left  = 0;

  function automatic longint bins_used();
    return (span_bins < NBINS) ? longint'(span_bins) : longint'(NBINS);
  endfunction

  function automatic void wipe_histogram();
    for (int i = 0; i < NBINS; i++) bin_tally[i] = '0;
    least_tof    = FLIGHT_TOP;
    greatest_tof = FLIGHT_BOTTOM;
  endfunction

  // advances the predicted state by one transaction and returns its result;
  // the block's window cache is left out, a cache hit must equal the plain sum
  function automatic hist_result_t apply_histogram(input hist_cmd_t c);
    hist_result_t r;
    longint       offset;
    longint       quot;
    longint       width;
    longint       sum;
    r = '0;
    case (c.op)
      OP_INSERT: begin
        if (span_width != 0) begin
          offset = longint'($signed(c.raw)) - longint'($signed(c.tof))
                 - longint'(span_left);
          width  = longint'(span_width);
          quot   = offset / width;
          // floor, not truncation toward zero
          if (offset % width != 0 && offset < 0) quot = quot - 1;
          if (quot >= 0 && quot < bins_used()) begin
            if (bin_tally[quot] < TALLY_MAX) bin_tally[quot] = bin_tally[quot] + 1'b1;
            if ($signed(c.tof) < least_tof)    least_tof    = c.tof;
            if ($signed(c.tof) > greatest_tof) greatest_tof = c.tof;
            r.accepted = 1'b1;
            r.hit_bin  = quot[BIN_FIELD_W-1:0];
          end
        end
      end
      OP_QUERY: begin
        sum = 0;
        if (c.first <= c.last) begin
          for (int i = c.first; i <= c.last && i < bins_used(); i++) begin
            sum = sum + bin_tally[i];
            if (sum > TOTAL_CEIL) sum = TOTAL_CEIL;
          end
        end
        r.window_total = sum[TOTAL_W-1:0];
      end
      OP_CLEAR: wipe_histogram();
      default: ;
    endcase
    r.flight_min = least_tof;
    r.flight_max = greatest_tof;
    return r;
  endfunction

  function automatic void load_register(input logic [CFG_ADDR_W-1:0] idx,
                                        input logic [CFG_DATA_W-1:0] data);
    case (idx)
      CFG_T_LEFT:    span_left  = data;
      CFG_BIN_WIDTH: span_width = data[WIDTH_W-1:0];
      CFG_BIN_COUNT: span_bins  = data[BCOUNT_W-1:0];
      default: ;
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // random transaction generator
  // ---------------------------------------------------------------------------
  function automatic hist_cmd_t random_command();
    hist_cmd_t c;
    int        pick;
    longint    bin_l;
    longint    off_l;
    longint    tof_l;
    longint    raw_l;
    longint    shift;
    int        lo;
    int        hi;
    // junk in the fields an operation does not use
    c.raw   = $urandom;
    c.tof   = $urandom;
    c.first = $urandom;
    c.last  = $urandom;
    pick    = $urandom_range(0, 99);
    if (pick < 58) begin
      c.op = OP_INSERT;
      if ($urandom_range(0, 9) < 8) begin
        // well formed hit: aim at a bin, then place raw time to land there
        case ($urandom_range(0, 9))
          0:       bin_l = 0;
          1:       bin_l = bins_used() - 1;
          2, 3, 4: bin_l = hot_bin;
          5:       bin_l = bins_used();   // one past the end
          6:       bin_l = -1;            // one before the start
          default: bin_l = (bins_used() > 0) ? $urandom_range(0, bins_used() - 1)
                                             : $urandom_range(0, NBINS - 1);
        endcase
        case ($urandom_range(0, 3))
          0:       off_l = 0;
          1:       off_l = (span_width == 0) ? 0 : longint'(span_width) - 1;
          default: off_l = (span_width == 0) ? 0 : $urandom_range(0, span_width - 1);
        endcase
        case ($urandom_range(0, 7))
          0, 1, 2: tof_l = longint'($urandom_range(0, 8192)) - 4096;
          3:       tof_l = TIME_BOTTOM;
          4:       tof_l = TIME_TOP;
          default: tof_l = longint'($signed($urandom));
        endcase
        raw_l = longint'(span_left) + tof_l + bin_l * longint'(span_width) + off_l;
        // keep raw time in range by moving the flight time with it
        if (raw_l > TIME_TOP) begin
          shift = raw_l - TIME_TOP + $urandom_range(0, 255);
          tof_l = tof_l - shift;
          raw_l = raw_l - shift;
        end else if (raw_l < TIME_BOTTOM) begin
          shift = TIME_BOTTOM - raw_l + $urandom_range(0, 255);
          tof_l = tof_l + shift;
          raw_l = raw_l + shift;
        end
        c.raw = raw_l[TIME_W-1:0];
        c.tof = tof_l[TIME_W-1:0];
      end
    end else if (pick < 92) begin
      c.op = OP_QUERY;
      case ($urandom_range(0, 9))
        0: begin
          c.first = prev_first;
          c.last  = prev_last;
        end
        1, 2: begin
          c.first = prev_first + 1'b1;
          c.last  = prev_last + 1'b1;
        end
        3: begin
          c.first = '0;
          c.last  = '1;
        end
        4: begin
          lo      = $urandom_range(1, NBINS - 1);
          c.first = lo;
          c.last  = $urandom_range(0, lo - 1);
        end
        5, 6: begin
          lo      = hot_bin;
          hi      = hot_bin + $urandom_range(0, 15);
          c.first = lo;
          c.last  = (hi > NBINS - 1) ? NBINS - 1 : hi;
        end
        7: begin
          lo      = (bins_used() < NBINS) ? bins_used() : NBINS - 4;
          c.first = lo;
          c.last  = '1;
        end
        default: ;
      endcase
      prev_first = c.first;
      prev_last  = c.last;
    end else if (pick < 94) begin
      c.op = OP_CLEAR;
    end else begin
      c.op = OP_UNUSED;
    end
    return c;
  endfunction

  // ---------------------------------------------------------------------------
  // driver tasks
  // ---------------------------------------------------------------------------

  // one command transaction: random gap, then hold start until busy is low
  task automatic send_command(input hist_cmd_t c, input logic typed,
                              input hist_result_t typed_want);
    int           gap;
    hist_result_t predicted;
    if (calm_left > 0) begin
      gap       = 0;
      calm_left = calm_left - 1;
    end else begin
      gap = $urandom_range(0, MAX_GAP);
      if ($urandom_range(0, 49) == 0) calm_left = $urandom_range(10, 40);
    end
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start          <= 1'b1;
    in_operation   <= c.op;
    in_raw_time    <= c.raw;
    in_flight_time <= c.tof;
    in_first_bin   <= c.first;
    in_last_bin    <= c.last;
    @(posedge clk);
    while (busy) @(posedge clk);
    // transaction taken at this edge
    predicted = apply_histogram(c);
    pending_results.insert(pending_results.size(), typed ? typed_want : predicted);
    case (c.op)
      OP_INSERT: begin
        n_inserts = n_inserts + 1;
        if (predicted.accepted) n_binned = n_binned + 1;
      end
      OP_QUERY: n_queries = n_queries + 1;
      OP_CLEAR: n_clears = n_clears + 1;
      default:  n_unused_ops = n_unused_ops + 1;
    endcase
  endtask

  // sender holds off until every expected result is back
  task automatic wait_quiet();
    start <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_register(input logic [CFG_ADDR_W-1:0] idx,
                                input logic [CFG_DATA_W-1:0] data);
    cfg_we   <= 1'b1;
    cfg_addr <= idx;
    cfg_data <= data;
    @(posedge clk);
    load_register(idx, data);
    cfg_we   <= 1'b0;
    n_writes = n_writes + 1;
    @(posedge clk);
  endtask

  // ---------------------------------------------------------------------------
  // directed table
  // ---------------------------------------------------------------------------
  table_row_t directed_rows [$];

  function automatic void add_row(input logic [OP_W-1:0] op,
                                  input logic [TIME_W-1:0] raw,
                                  input logic [TIME_W-1:0] tof,
                                  input int first, input int last);
    table_row_t row;
    row           = '0;
    row.cmd.op    = op;
    row.cmd.raw   = raw;
    row.cmd.tof   = tof;
    row.cmd.first = first;
    row.cmd.last  = last;
    directed_rows.insert(directed_rows.size(), row);
  endfunction

  // row whose result is written out by hand
  function automatic void add_known(input logic [OP_W-1:0] op,
                                    input logic [TIME_W-1:0] raw,
                                    input logic [TIME_W-1:0] tof,
                                    input int first, input int last,
                                    input logic acc, input int bin, input int total,
                                    input logic [TIME_W-1:0] fmin,
                                    input logic [TIME_W-1:0] fmax);
    add_row(op, raw, tof, first, last);
    directed_rows[$].typed             = 1'b1;
    directed_rows[$].want.accepted     = acc;
    directed_rows[$].want.hit_bin      = bin;
    directed_rows[$].want.window_total = total;
    directed_rows[$].want.flight_min   = fmin;
    directed_rows[$].want.flight_max   = fmax;
  endfunction

  function automatic void add_write(input logic [CFG_ADDR_W-1:0] idx,
                                    input logic [CFG_DATA_W-1:0] data);
    table_row_t row;
    row          = '0;
    row.is_write = 1'b1;
    row.reg_idx  = idx;
    row.wdata    = data;
    directed_rows.insert(directed_rows.size(), row);
  endfunction

  function automatic void build_directed();
    // reset span: left edge 0, 16 per bin, 1024 bins
    // empty histogram, extremes at their idle values
    add_known(OP_QUERY, 0, 0, 0, NBINS - 1, 0, 0, 0, FLIGHT_TOP, FLIGHT_BOTTOM);
    // undefined operation changes nothing
    add_known(OP_UNUSED, FLIGHT_TOP, FLIGHT_BOTTOM, NBINS - 1, 0,
              0, 0, 0, FLIGHT_TOP, FLIGHT_BOTTOM);
    // first and last bin edges, then just outside on both sides
    add_known(OP_INSERT, 0, 0, 0, 0, 1, 0, 0, 0, 0);
    add_known(OP_INSERT, 16 * NBINS - 1, 0, 0, 0, 1, NBINS - 1, 0, 0, 0);
    add_known(OP_INSERT, 16 * NBINS, 0, 0, 0, 0, 0, 0, 0, 0);
    add_known(OP_INSERT, -1, 0, 0, 0, 0, 0, 0, 0, 0);
    // time extremes, far out of span
    add_row(OP_INSERT, FLIGHT_TOP, FLIGHT_BOTTOM, 0, 0);
    add_row(OP_INSERT, FLIGHT_BOTTOM, FLIGHT_TOP, 0, 0);
    // time extremes that still land in span, pushing both flight extremes
    add_row(OP_INSERT, FLIGHT_BOTTOM + 100, FLIGHT_BOTTOM, 0, 0);
    add_row(OP_INSERT, FLIGHT_TOP, FLIGHT_TOP - 50, 0, 0);
    // full window, repeat, slide by one, reversed, last bin alone
    add_row(OP_QUERY, 0, 0, 0, NBINS - 1);
    add_row(OP_QUERY, 0, 0, 0, NBINS - 1);
    add_row(OP_QUERY, 0, 0, 2, 5);
    add_row(OP_QUERY, 0, 0, 3, 6);
    add_row(OP_QUERY, 0, 0, 6, 3);
    add_row(OP_QUERY, 0, 0, NBINS - 1, NBINS - 1);
    // clear drops counts and extremes
    add_known(OP_CLEAR, 0, 0, 0, 0, 0, 0, 0, FLIGHT_TOP, FLIGHT_BOTTOM);
    add_known(OP_QUERY, 0, 0, 0, NBINS - 1, 0, 0, 0, FLIGHT_TOP, FLIGHT_BOTTOM);
    add_row(OP_INSERT, 32, 0, 0, 0);
    // zero bin width rejects everything
    add_write(CFG_BIN_WIDTH, 32'h0);
    add_row(OP_INSERT, 32, 0, 0, 0);
    // widest bins, upper data bits ignored; zero bins in use
    add_write(CFG_BIN_WIDTH, 32'hFFFF_FFFF);
    add_write(CFG_BIN_COUNT, 32'h0);
    add_row(OP_INSERT, 0, 0, 0, 0);
    add_row(OP_QUERY, 0, 0, 0, NBINS - 1);
    // bin count beyond the store is capped at the store size
    add_write(CFG_BIN_COUNT, 32'hFFFF_FFFF);
    add_write(CFG_T_LEFT, FLIGHT_BOTTOM);
    add_row(OP_INSERT, FLIGHT_BOTTOM, 0, 0, 0);
    add_write(CFG_T_LEFT, FLIGHT_TOP);
    add_row(OP_INSERT, FLIGHT_TOP, -(65535 * (NBINS - 1)), 0, 0);
    // single bin of width one; a write to the spare index is ignored
    add_write(CFG_BIN_WIDTH, 32'h1);
    add_write(CFG_BIN_COUNT, 32'h1);
    add_write(CFG_T_LEFT, 32'h0);
    add_write(CFG_NO_REG, 32'hA5A5_5A5A);
    add_row(OP_INSERT, 0, 0, 0, 0);
    add_row(OP_INSERT, 1, 0, 0, 0);
    add_row(OP_QUERY, 0, 0, 0, NBINS - 1);
  endfunction

  // random register setting per phase, extremes weighted up
  task automatic pick_setting();
    logic [CFG_DATA_W-1:0] data;
    int                    pick;
    pick = $urandom_range(0, 19);
    if (pick == 0)      data = 0;
    else if (pick < 3)  data = 1;
    else if (pick < 5)  data = 65535;
    else if (pick < 12) data = $urandom_range(1, 64);
    else                data = $urandom_range(1, 65535);
    if ($urandom_range(0, 3) == 0) data[CFG_DATA_W-1:WIDTH_W] = $urandom;
    write_register(CFG_BIN_WIDTH, data);
    pick = $urandom_range(0, 19);
    if (pick == 0)      data = 0;
    else if (pick < 3)  data = 1;
    else if (pick < 5)  data = NBINS;
    else if (pick < 7)  data = $urandom_range(NBINS + 1, 2047);
    else                data = $urandom_range(1, NBINS);
    if ($urandom_range(0, 3) == 0) data[CFG_DATA_W-1:BCOUNT_W] = $urandom;
    write_register(CFG_BIN_COUNT, data);
    pick = $urandom_range(0, 19);
    if (pick < 2)       data = FLIGHT_BOTTOM;
    else if (pick < 4)  data = FLIGHT_TOP;
    else if (pick < 11) data = $urandom_range(0, 2000) - 1000;
    else                data = $urandom;
    write_register(CFG_T_LEFT, data);
    if ($urandom_range(0, 19) == 0) write_register(CFG_NO_REG, $urandom);
    hot_bin    = (bins_used() > 0) ? $urandom_range(0, bins_used() - 1) : 0;
    n_settings = n_settings + 1;
  endtask

  // ---------------------------------------------------------------------------
  // stimulus sequence
  // ---------------------------------------------------------------------------
  initial begin
    table_row_t row;
    int         sent;
    int         phase_len;
    wipe_histogram();
    build_directed();
    // synchronous reset, then the block runs its zeroing pass while busy
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // directed table; register writes only once the block is quiet
    n_settings = 1;
    foreach (directed_rows[i]) begin
      row = directed_rows[i];
      if (row.is_write) begin
        wait_quiet();
        write_register(row.reg_idx, row.wdata);
      end else begin
        send_command(row.cmd, row.typed, row.want);
      end
    end

    // random phases, each under a fresh setting after a full drain
    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      wait_quiet();
      pick_setting();
      phase_len = $urandom_range(60, 200);
      for (int k = 0; k < phase_len; k++) begin
        send_command(random_command(), 1'b0, '0);
        sent = sent + 1;
      end
    end

    // drain, then give a zeroing pass time to show any stray result
    start <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("%0d results checked: %0d inserts (%0d binned), %0d window sums, %0d clears, %0d unused ops",
             result_count, n_inserts, n_binned, n_queries, n_clears, n_unused_ops);
    $display("%0d register writes over %0d span settings, %0d mismatches, %0d results missing",
             n_writes, n_settings, mismatch_count, pending_results.size());
    if (mismatch_count == 0 && pending_results.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  // ---------------------------------------------------------------------------
  // result checker: every strobe is matched against the oldest expectation
  // ---------------------------------------------------------------------------
  hist_result_t seen;
  hist_result_t oldest;

  always @(posedge clk) begin
    if (rst_n && out_valid) begin
      seen.accepted     = out_accepted;
      seen.hit_bin      = out_hit_bin;
      seen.window_total = out_window_total;
      seen.flight_min   = out_flight_min;
      seen.flight_max   = out_flight_max;
      if (pending_results.size() == 0) begin
        // result with nothing outstanding
        mismatch_count = mismatch_count + 1;
        if (mismatch_count <= REPORT_LIMIT) begin
          $display("cycle %0d: unexpected result acc=%0d bin=%0d total=%0d min=%0d max=%0d",
                   cycle_count, seen.accepted, seen.hit_bin, seen.window_total,
                   $signed(seen.flight_min), $signed(seen.flight_max));
        end
      end else begin
        oldest       = pending_results.pop_front();
        result_count = result_count + 1;
        if (seen.accepted !== oldest.accepted || seen.hit_bin !== oldest.hit_bin ||
            seen.window_total !== oldest.window_total ||
            seen.flight_min !== oldest.flight_min ||
            seen.flight_max !== oldest.flight_max) begin
          mismatch_count = mismatch_count + 1;
          if (mismatch_count <= REPORT_LIMIT) begin
            $display("cycle %0d: result %0d expected acc=%0d bin=%0d total=%0d min=%0d max=%0d",
                     cycle_count, result_count, oldest.accepted, oldest.hit_bin,
                     oldest.window_total, $signed(oldest.flight_min),
                     $signed(oldest.flight_max));
            $display("cycle %0d: result %0d got      acc=%0d bin=%0d total=%0d min=%0d max=%0d",
                     cycle_count, result_count, seen.accepted, seen.hit_bin,
                     seen.window_total, $signed(seen.flight_min), $signed(seen.flight_max));
          end
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // watchdog
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    cycle_count = cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding",
               cycle_count, pending_results.size());
      $display("Test completed with failures");
      $finish;
    end
  end

endmodule
